// ===== src/lcs_pkg.sv =====
// Package of the lock and condition server: opcodes, reply status codes,
// the reply record and default sizes. Used by the server core and its testbench.
`default_nettype none
package lcs_pkg;

    localparam int DEF_NUM_LOCKS  = 64;
    localparam int DEF_NUM_CONDS  = 64;
    localparam int DEF_WAIT_DEPTH = 16;

    localparam int CLIENT_W = 12;
    localparam int STATUS_W = 5;
    localparam int INDEX_W  = 6;

    localparam logic [3:0] OP_CREATE_LOCK  = 4'd0;
    localparam logic [3:0] OP_ACQUIRE      = 4'd1;
    localparam logic [3:0] OP_RELEASE      = 4'd2;
    localparam logic [3:0] OP_DESTROY_LOCK = 4'd3;
    localparam logic [3:0] OP_CREATE_COND  = 4'd4;
    localparam logic [3:0] OP_WAIT         = 4'd5;
    localparam logic [3:0] OP_SIGNAL       = 4'd6;
    localparam logic [3:0] OP_BROADCAST    = 4'd7;
    localparam logic [3:0] OP_DESTROY_COND = 4'd8;

    localparam logic [4:0] ST_CREATED       = 5'd0;
    localparam logic [4:0] ST_TOO_MANY      = 5'd1;
    localparam logic [4:0] ST_BAD_LOCK      = 5'd2;
    localparam logic [4:0] ST_ALREADY_OWNER = 5'd3;
    localparam logic [4:0] ST_GRANTED       = 5'd4;
    localparam logic [4:0] ST_NO_PERMISSION = 5'd5;
    localparam logic [4:0] ST_REL_DELETED   = 5'd6;
    localparam logic [4:0] ST_REL_HANDED    = 5'd7;
    localparam logic [4:0] ST_RELEASED      = 5'd8;
    localparam logic [4:0] ST_DELETE_LATER  = 5'd9;
    localparam logic [4:0] ST_DESTROYED     = 5'd10;
    localparam logic [4:0] ST_BAD_COND      = 5'd11;
    localparam logic [4:0] ST_NOT_ACQUIRED  = 5'd12;
    localparam logic [4:0] ST_COND_CLOSING  = 5'd13;
    localparam logic [4:0] ST_NO_WAITER     = 5'd14;
    localparam logic [4:0] ST_SIGNALLED     = 5'd15;
    localparam logic [4:0] ST_QUEUE_FULL    = 5'd16;

    typedef struct packed {
        logic [CLIENT_W-1:0] who;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  idx;
        logic                last;
    } rep_t;

    function automatic rep_t mk_rep(input logic [CLIENT_W-1:0] who,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [INDEX_W-1:0] idx,
                                    input logic last);
        rep_t r;
        r.who    = who;
        r.status = status;
        r.idx    = idx;
        r.last   = last;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/lcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== src/lock_and_condition_server_core.sv =====
// Top level of the lock and condition server: request sequencer around four RAMs.
// Depends on lcs_pkg and lcs_ram.
`default_nettype none
// The server takes one request at a time on the input stream and answers with
// zero or more reply transfers on the output stream, the final reply of each
// request marked by tlast. Lock records, condition records and the two waiter
// queue stores live in RAMs with a registered read; each request reads its
// lock and condition records, works on copies and writes them back at the end.
// A simple request passes through the load, decide, emit and write-back states;
// a signal adds the waiter pop and its acquire, and a broadcast repeats both
// per waiter, since each waiter is read from the condition queue RAM and
// acquired in turn. A stalled output holds the sequencer at its next reply.
// No clearing pass is needed after reset: a record is only used once its
// create has written it.
module lock_and_condition_server_core #(
    parameter int NUM_LOCKS  = lcs_pkg::DEF_NUM_LOCKS,
    parameter int NUM_CONDS  = lcs_pkg::DEF_NUM_CONDS,
    parameter int WAIT_DEPTH = lcs_pkg::DEF_WAIT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[3:0], lock_index[9:4], cond_index[15:10],
    // client_machine[23:16], client_mailbox[27:24], zero[31:28]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // dest_machine[7:0], dest_mailbox[11:8], status[16:12],
    // new_index[22:17], zero[23]
    output logic      [23:0] m_axis_tdata,
    output logic             m_axis_tlast
);
    import lcs_pkg::*;

    localparam int LAW  = NUM_LOCKS > 1 ? $clog2(NUM_LOCKS) : 1;
    localparam int CAW  = NUM_CONDS > 1 ? $clog2(NUM_CONDS) : 1;
    localparam int LCW  = $clog2(NUM_LOCKS + 1);
    localparam int CCW  = $clog2(NUM_CONDS + 1);
    localparam int LIW  = LCW > INDEX_W ? LCW : INDEX_W;
    localparam int CIW  = CCW > INDEX_W ? CCW : INDEX_W;
    localparam int HW   = $clog2(WAIT_DEPTH);
    localparam int FW   = $clog2(WAIT_DEPTH + 1);
    localparam int LWD  = NUM_LOCKS * WAIT_DEPTH;
    localparam int CWD  = NUM_CONDS * WAIT_DEPTH;
    localparam int LWAW = $clog2(LWD);
    localparam int CWAW = $clog2(CWD);

    typedef struct packed {
        logic                busy;
        logic [CLIENT_W-1:0] owner;
        logic                dpend;
        logic                deleted;
        logic [HW-1:0]       head;
        logic [FW-1:0]       fill;
    } lmeta_t;

    typedef struct packed {
        logic          dpend;
        logic          deleted;
        logic          bound;
        logic [LAW-1:0] blk;
        logic [HW-1:0] head;
        logic [FW-1:0] fill;
    } cmeta_t;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD     = 4'd1;
    localparam logic [3:0] S_DECIDE   = 4'd2;
    localparam logic [3:0] S_EMIT     = 4'd3;
    localparam logic [3:0] S_ACQ      = 4'd4;
    localparam logic [3:0] S_ACQ_DONE = 4'd5;
    localparam logic [3:0] S_HAND     = 4'd6;
    localparam logic [3:0] S_LHAND    = 4'd7;
    localparam logic [3:0] S_CRD      = 4'd8;
    localparam logic [3:0] S_CPOP     = 4'd9;
    localparam logic [3:0] S_WB       = 4'd10;

    // Circular slot after head for a given fill; the sum stays below twice the depth.
    function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] h,
                                              input logic [FW-1:0] f);
        logic [FW:0] s;
        s = (FW+1)'(h) + (FW+1)'(f);
        if (s >= (FW+1)'(WAIT_DEPTH))
        begin
            s = s - (FW+1)'(WAIT_DEPTH);
        end
        return s[HW-1:0];
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [3:0]          ret_reg, ret_next;
    logic [3:0]          op_reg, op_next;
    logic [LAW-1:0]      la_reg, la_next;
    logic [CAW-1:0]      ca_reg, ca_next;
    logic [CLIENT_W-1:0] who_reg, who_next;
    logic [CLIENT_W-1:0] tgt_reg, tgt_next;
    logic                lrange_reg, lrange_next;
    logic                crange_reg, crange_next;
    logic                wl_reg, wl_next;
    logic                wc_reg, wc_next;
    lmeta_t              lm_reg, lm_next;
    cmeta_t              cm_reg, cm_next;
    logic [LCW-1:0]      lcnt_reg, lcnt_next;
    logic [CCW-1:0]      ccnt_reg, ccnt_next;
    rep_t                rep_reg, rep_next;
    logic                out_valid_reg, out_valid_next;
    logic [23:0]         out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic [3:0]          in_op;
    logic [INDEX_W-1:0]  in_lock;
    logic [INDEX_W-1:0]  in_cond;
    logic [CLIENT_W-1:0] in_who;
    logic                accept;
    logic                lock_ok, cond_ok, is_owner, tgt_owner;

    logic [LAW-1:0]      lm_rd_addr;
    logic [CAW-1:0]      cm_rd_addr;
    logic [$bits(lmeta_t)-1:0] lm_rd_data;
    logic [$bits(cmeta_t)-1:0] cm_rd_data;
    logic                lw_we, cw_we;
    logic [LWAW-1:0]     lw_wr_addr, lw_rd_addr;
    logic [CWAW-1:0]     cw_wr_addr, cw_rd_addr;
    logic [CLIENT_W-1:0] lw_wr_data, cw_wr_data, lw_rd_data, cw_rd_data;

    assign in_op   = s_axis_tdata[3:0];
    assign in_lock = s_axis_tdata[9:4];
    assign in_cond = s_axis_tdata[15:10];
    assign in_who  = {s_axis_tdata[23:16], s_axis_tdata[27:24]};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    assign lock_ok   = lrange_reg && !lm_reg.deleted;
    assign cond_ok   = crange_reg && !cm_reg.deleted;
    assign is_owner  = lm_reg.busy && (lm_reg.owner == who_reg);
    assign tgt_owner = lm_reg.busy && (lm_reg.owner == tgt_reg);

    // Metadata reads: the incoming index (the next free one on a create) while idle, the held one afterwards.
    assign lm_rd_addr = (state_reg == S_IDLE) ?
        ((in_op == OP_CREATE_LOCK) ? lcnt_reg[LAW-1:0] : LAW'(in_lock)) : la_reg;
    assign cm_rd_addr = (state_reg == S_IDLE) ?
        ((in_op == OP_CREATE_COND) ? ccnt_reg[CAW-1:0] : CAW'(in_cond)) : ca_reg;

    // Waiter queue reads always point at the current head entry.
    assign lw_rd_addr = LWAW'(la_reg) * LWAW'(WAIT_DEPTH) + LWAW'(lm_reg.head);
    assign cw_rd_addr = CWAW'(ca_reg) * CWAW'(WAIT_DEPTH) + CWAW'(cm_reg.head);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        op_next        = op_reg;
        la_next        = la_reg;
        ca_next        = ca_reg;
        who_next       = who_reg;
        tgt_next       = tgt_reg;
        lrange_next    = lrange_reg;
        crange_next    = crange_reg;
        wl_next        = wl_reg;
        wc_next        = wc_reg;
        lm_next        = lm_reg;
        cm_next        = cm_reg;
        lcnt_next      = lcnt_reg;
        ccnt_next      = ccnt_reg;
        rep_next       = rep_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        lw_we          = 1'b0;
        lw_wr_addr     = LWAW'(la_reg) * LWAW'(WAIT_DEPTH)
                         + LWAW'(slot_of(lm_reg.head, lm_reg.fill));
        lw_wr_data     = tgt_reg;
        cw_we          = 1'b0;
        cw_wr_addr     = CWAW'(ca_reg) * CWAW'(WAIT_DEPTH)
                         + CWAW'(slot_of(cm_reg.head, cm_reg.fill));
        cw_wr_data     = who_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    who_next    = in_who;
                    la_next     = lm_rd_addr;
                    ca_next     = cm_rd_addr;
                    lrange_next = LIW'(in_lock) < LIW'(lcnt_reg);
                    crange_next = CIW'(in_cond) < CIW'(ccnt_reg);
                    wl_next     = 1'b0;
                    wc_next     = 1'b0;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                lm_next    = lmeta_t'(lm_rd_data);
                cm_next    = cmeta_t'(cm_rd_data);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_EMIT;
                ret_next   = S_WB;
                unique case (op_reg)
                    OP_CREATE_LOCK:
                    begin
                        if (lcnt_reg == LCW'(NUM_LOCKS))
                        begin
                            rep_next = mk_rep(who_reg, ST_TOO_MANY, '0, 1'b1);
                        end
                        else
                        begin
                            lm_next   = '0;
                            wl_next   = 1'b1;
                            lcnt_next = lcnt_reg + LCW'(1);
                            rep_next  = mk_rep(who_reg, ST_CREATED, INDEX_W'(la_reg), 1'b1);
                        end
                    end
                    OP_ACQUIRE:
                    begin
                        tgt_next   = who_reg;
                        state_next = S_ACQ;
                    end
                    OP_RELEASE:
                    begin
                        if (!lock_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_LOCK, '0, 1'b1);
                        end
                        else if (!is_owner)
                        begin
                            rep_next = mk_rep(who_reg, ST_NO_PERMISSION, '0, 1'b1);
                        end
                        else if (lm_reg.dpend)
                        begin
                            lm_next.deleted = 1'b1;
                            lm_next.busy    = 1'b0;
                            lm_next.owner   = '0;
                            lm_next.head    = '0;
                            lm_next.fill    = '0;
                            wl_next         = 1'b1;
                            rep_next = mk_rep(who_reg, ST_REL_DELETED, '0, 1'b1);
                        end
                        else if (lm_reg.fill != '0)
                        begin
                            rep_next = mk_rep(who_reg, ST_REL_HANDED, '0, 1'b0);
                            ret_next = S_HAND;
                        end
                        else
                        begin
                            lm_next.busy  = 1'b0;
                            lm_next.owner = '0;
                            wl_next       = 1'b1;
                            rep_next = mk_rep(who_reg, ST_RELEASED, '0, 1'b1);
                        end
                    end
                    OP_DESTROY_LOCK:
                    begin
                        if (!lock_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_LOCK, '0, 1'b1);
                        end
                        else if (lm_reg.busy)
                        begin
                            lm_next.dpend = 1'b1;
                            wl_next       = 1'b1;
                            rep_next = mk_rep(who_reg, ST_DELETE_LATER, '0, 1'b1);
                        end
                        else
                        begin
                            lm_next.deleted = 1'b1;
                            wl_next         = 1'b1;
                            rep_next = mk_rep(who_reg, ST_DESTROYED, '0, 1'b1);
                        end
                    end
                    OP_CREATE_COND:
                    begin
                        if (ccnt_reg == CCW'(NUM_CONDS))
                        begin
                            rep_next = mk_rep(who_reg, ST_TOO_MANY, '0, 1'b1);
                        end
                        else
                        begin
                            cm_next   = '0;
                            wc_next   = 1'b1;
                            ccnt_next = ccnt_reg + CCW'(1);
                            rep_next  = mk_rep(who_reg, ST_CREATED, INDEX_W'(ca_reg), 1'b1);
                        end
                    end
                    OP_WAIT:
                    begin
                        if (!lock_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_LOCK, '0, 1'b1);
                        end
                        else if (!cond_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_COND, '0, 1'b1);
                        end
                        else if (!is_owner)
                        begin
                            rep_next = mk_rep(who_reg, ST_NOT_ACQUIRED, '0, 1'b1);
                        end
                        else if (cm_reg.dpend)
                        begin
                            rep_next = mk_rep(who_reg, ST_COND_CLOSING, '0, 1'b1);
                        end
                        else if (cm_reg.bound && (cm_reg.blk != la_reg))
                        begin
                            rep_next = mk_rep(who_reg, ST_NO_PERMISSION, '0, 1'b1);
                        end
                        else if (cm_reg.fill == FW'(WAIT_DEPTH))
                        begin
                            rep_next = mk_rep(who_reg, ST_QUEUE_FULL, '0, 1'b1);
                        end
                        else
                        begin
                            // Queue the caller on the condition, then pass the lock on.
                            cw_we         = 1'b1;
                            cm_next.bound = 1'b1;
                            cm_next.blk   = la_reg;
                            cm_next.fill  = cm_reg.fill + FW'(1);
                            wc_next       = 1'b1;
                            if (lm_reg.fill != '0)
                            begin
                                state_next = S_HAND;
                            end
                            else
                            begin
                                lm_next.busy  = 1'b0;
                                lm_next.owner = '0;
                                wl_next       = 1'b1;
                                state_next    = S_WB;
                            end
                        end
                    end
                    OP_SIGNAL:
                    begin
                        if (!cond_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_COND, '0, 1'b1);
                        end
                        else if (cm_reg.fill == '0)
                        begin
                            cm_next.bound = 1'b0;
                            cm_next.blk   = '0;
                            wc_next       = 1'b1;
                            rep_next = mk_rep(who_reg, ST_NO_WAITER, '0, 1'b1);
                        end
                        else
                        begin
                            state_next = S_CRD;
                        end
                    end
                    OP_BROADCAST:
                    begin
                        if (!lock_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_LOCK, '0, 1'b1);
                        end
                        else if (!cond_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_COND, '0, 1'b1);
                        end
                        else if (cm_reg.bound && (cm_reg.blk != la_reg))
                        begin
                            rep_next = mk_rep(who_reg, ST_NO_PERMISSION, '0, 1'b1);
                        end
                        else if (cm_reg.fill != '0)
                        begin
                            state_next = S_CRD;
                        end
                        else
                        begin
                            cm_next.bound = 1'b0;
                            cm_next.blk   = '0;
                            wc_next       = 1'b1;
                            rep_next = mk_rep(who_reg, ST_SIGNALLED, '0, 1'b1);
                        end
                    end
                    OP_DESTROY_COND:
                    begin
                        if (!cond_ok)
                        begin
                            rep_next = mk_rep(who_reg, ST_BAD_COND, '0, 1'b1);
                        end
                        else if (cm_reg.fill == '0)
                        begin
                            cm_next.deleted = 1'b1;
                            wc_next         = 1'b1;
                            rep_next = mk_rep(who_reg, ST_DESTROYED, '0, 1'b1);
                        end
                        else
                        begin
                            cm_next.dpend = 1'b1;
                            wc_next       = 1'b1;
                            rep_next = mk_rep(who_reg, ST_DELETE_LATER, '0, 1'b1);
                        end
                    end
                    default:
                    begin
                        // Unknown operations are dropped without a reply.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, rep_reg.idx, rep_reg.status,
                                      rep_reg.who[3:0], rep_reg.who[CLIENT_W-1:4]};
                    out_last_next  = rep_reg.last;
                    state_next     = ret_reg;
                end
            end
            S_ACQ:
            begin
                // Acquire the lock on behalf of tgt_reg; only an acquire request
                // ends with this reply.
                state_next = S_EMIT;
                ret_next   = S_ACQ_DONE;
                if (!lock_ok)
                begin
                    rep_next = mk_rep(tgt_reg, ST_BAD_LOCK, '0, op_reg == OP_ACQUIRE);
                end
                else if (tgt_owner)
                begin
                    rep_next = mk_rep(tgt_reg, ST_ALREADY_OWNER, '0, op_reg == OP_ACQUIRE);
                end
                else if (!lm_reg.busy)
                begin
                    lm_next.busy  = 1'b1;
                    lm_next.owner = tgt_reg;
                    wl_next       = 1'b1;
                    rep_next = mk_rep(tgt_reg, ST_GRANTED, '0, op_reg == OP_ACQUIRE);
                end
                else if (lm_reg.fill == FW'(WAIT_DEPTH))
                begin
                    rep_next = mk_rep(tgt_reg, ST_QUEUE_FULL, '0, op_reg == OP_ACQUIRE);
                end
                else
                begin
                    lw_we        = 1'b1;
                    lm_next.fill = lm_reg.fill + FW'(1);
                    wl_next      = 1'b1;
                    state_next   = S_ACQ_DONE;
                end
            end
            S_ACQ_DONE:
            begin
                if (op_reg == OP_ACQUIRE)
                begin
                    state_next = S_WB;
                end
                else if ((op_reg == OP_BROADCAST) && (cm_reg.fill != '0))
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    rep_next   = mk_rep(who_reg, ST_SIGNALLED, '0, 1'b1);
                    ret_next   = S_WB;
                    state_next = S_EMIT;
                end
            end
            S_HAND:
            begin
                // Lock waiter RAM read of the head entry is in flight.
                state_next = S_LHAND;
            end
            S_LHAND:
            begin
                lm_next.head  = slot_of(lm_reg.head, FW'(1));
                lm_next.fill  = lm_reg.fill - FW'(1);
                lm_next.owner = lw_rd_data;
                wl_next       = 1'b1;
                rep_next      = mk_rep(lw_rd_data, ST_GRANTED, '0, 1'b1);
                ret_next      = S_WB;
                state_next    = S_EMIT;
            end
            S_CRD:
            begin
                state_next = S_CPOP;
            end
            S_CPOP:
            begin
                tgt_next     = cw_rd_data;
                cm_next.head = slot_of(cm_reg.head, FW'(1));
                cm_next.fill = cm_reg.fill - FW'(1);
                if (cm_reg.fill == FW'(1))
                begin
                    cm_next.bound = 1'b0;
                    cm_next.blk   = '0;
                end
                wc_next    = 1'b1;
                state_next = S_ACQ;
            end
            S_WB:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lcnt_reg      <= '0;
            ccnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            wl_reg        <= 1'b0;
            wc_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcnt_reg      <= lcnt_next;
            ccnt_reg      <= ccnt_next;
            out_valid_reg <= out_valid_next;
            wl_reg        <= wl_next;
            wc_reg        <= wc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg      <= ret_next;
        op_reg       <= op_next;
        la_reg       <= la_next;
        ca_reg       <= ca_next;
        who_reg      <= who_next;
        tgt_reg      <= tgt_next;
        lrange_reg   <= lrange_next;
        crange_reg   <= crange_next;
        lm_reg       <= lm_next;
        cm_reg       <= cm_next;
        rep_reg      <= rep_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    lcs_ram #(.WIDTH($bits(lmeta_t)), .DEPTH(NUM_LOCKS)) u_lock_meta (
        .clk     (clk),
        .wr_en   ((state_reg == S_WB) && wl_reg),
        .wr_addr (la_reg),
        .wr_data (lm_reg),
        .rd_addr (lm_rd_addr),
        .rd_data (lm_rd_data)
    );

    lcs_ram #(.WIDTH($bits(cmeta_t)), .DEPTH(NUM_CONDS)) u_cond_meta (
        .clk     (clk),
        .wr_en   ((state_reg == S_WB) && wc_reg),
        .wr_addr (ca_reg),
        .wr_data (cm_reg),
        .rd_addr (cm_rd_addr),
        .rd_data (cm_rd_data)
    );

    lcs_ram #(.WIDTH(CLIENT_W), .DEPTH(LWD)) u_lock_wait (
        .clk     (clk),
        .wr_en   (lw_we),
        .wr_addr (lw_wr_addr),
        .wr_data (lw_wr_data),
        .rd_addr (lw_rd_addr),
        .rd_data (lw_rd_data)
    );

    lcs_ram #(.WIDTH(CLIENT_W), .DEPTH(CWD)) u_cond_wait (
        .clk     (clk),
        .wr_en   (cw_we),
        .wr_addr (cw_wr_addr),
        .wr_data (cw_wr_data),
        .rd_addr (cw_rd_addr),
        .rd_data (cw_rd_data)
    );

    // A lock record written back never holds more waiters than the queue depth.
    a_lock_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) && wl_reg |-> lm_reg.fill <= FW'(WAIT_DEPTH))
        else $error("lock queue fill beyond depth at write-back");

    // A reply whose slot is free is on the output after the next edge.
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready) |=> m_axis_tvalid)
        else $error("reply lost on its way to the output register");

    // An accepted request always leaves the idle state.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("request accepted while another is still in work");

endmodule
`default_nettype wire

// ===== tb/lock_and_condition_server_core_tb.sv =====
// Self-checking testbench of the lock and condition server core.
// Depends on lcs_pkg and the server RTL; drives request transfers and checks replies
// against a built-in model of the lock, condition and waiter queue state.
`timescale 1ns / 100ps
module lock_and_condition_server_core_tb;
    import lcs_pkg::*;

    localparam int NL = DEF_NUM_LOCKS;
    localparam int NC = DEF_NUM_CONDS;
    localparam int WD = DEF_WAIT_DEPTH;

    typedef struct packed {
        logic [3:0]  op;
        logic [5:0]  lk;
        logic [5:0]  cv;
        logic [11:0] who;
    } req_t;

    typedef struct packed {
        logic [11:0] who;
        logic [4:0]  status;
        logic [5:0]  idx;
        logic        last;
    } reply_t;

    // Directed rows: a request plus an optional first reply status that can be read at a glance.
    typedef struct packed {
        req_t        rq;
        logic        has_fixed;
        logic [4:0]  fixed_status;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic m_axis_tlast;

    always #6 clk = ~clk;

    lock_and_condition_server_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // Server state as the predictor sees it.
    int           n_locks, n_conds;
    bit           l_busy[NL], l_delp[NL], l_del[NL];
    logic [11:0]  l_owner[NL];
    logic [11:0]  l_q[NL][WD];
    int           l_head[NL], l_fill[NL];
    bit           c_delp[NC], c_del[NC], c_bound[NC];
    logic [5:0]   c_lock[NC];
    logic [11:0]  c_q[NC][WD];
    int           c_head[NC], c_fill[NC];

    reply_t expected_replies[$];
    reply_t batch[$];
    int     error_count = 0;
    bit     hold_output = 1'b0;

    task automatic report(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function automatic void put(input logic [11:0] who, input logic [4:0] st,
                                input logic [5:0] idx);
        reply_t r;
        r.who = who; r.status = st; r.idx = idx; r.last = 1'b0;
        batch.push_back(r);
    endfunction

    function automatic bit lock_valid(input int l);
        return l < n_locks && !l_del[l];
    endfunction

    function automatic bit cond_valid(input int c);
        return c < n_conds && !c_del[c];
    endfunction

    function automatic void acquire_on_behalf(input int l, input logic [11:0] who);
        if (!lock_valid(l)) put(who, ST_BAD_LOCK, 0);
        else if (l_busy[l] && l_owner[l] == who) put(who, ST_ALREADY_OWNER, 0);
        else if (!l_busy[l]) begin
            l_busy[l] = 1; l_owner[l] = who; put(who, ST_GRANTED, 0);
        end
        else if (l_fill[l] >= WD) put(who, ST_QUEUE_FULL, 0);
        else begin
            l_q[l][(l_head[l] + l_fill[l]) % WD] = who;
            l_fill[l]++;
        end
    endfunction

    function automatic void pass_lock_on(input int l);
        logic [11:0] w;
        if (l_fill[l] > 0) begin
            w = l_q[l][l_head[l]];
            l_head[l] = (l_head[l] + 1) % WD;
            l_fill[l]--;
            l_owner[l] = w;
            put(w, ST_GRANTED, 0);
        end
        else begin
            l_busy[l] = 0; l_owner[l] = 0;
        end
    endfunction

    function automatic logic [11:0] pop_cond_waiter(input int c);
        logic [11:0] w;
        w = c_q[c][c_head[c]];
        c_head[c] = (c_head[c] + 1) % WD;
        c_fill[c]--;
        return w;
    endfunction

    // Works out the replies of one request and queues them as expected.
    function automatic int predict_replies(input req_t rq);
        int l, c, n;
        l = rq.lk; c = rq.cv;
        batch.delete();
        case (rq.op)
            OP_CREATE_LOCK:
                if (n_locks >= NL) put(rq.who, ST_TOO_MANY, 0);
                else begin
                    l_busy[n_locks] = 0; l_owner[n_locks] = 0; l_delp[n_locks] = 0;
                    l_del[n_locks] = 0; l_head[n_locks] = 0; l_fill[n_locks] = 0;
                    put(rq.who, ST_CREATED, n_locks[5:0]);
                    n_locks++;
                end
            OP_ACQUIRE: acquire_on_behalf(l, rq.who);
            OP_RELEASE:
                if (!lock_valid(l)) put(rq.who, ST_BAD_LOCK, 0);
                else if (!(l_busy[l] && l_owner[l] == rq.who)) put(rq.who, ST_NO_PERMISSION, 0);
                else if (l_delp[l]) begin
                    l_del[l] = 1; l_busy[l] = 0; l_owner[l] = 0;
                    l_head[l] = 0; l_fill[l] = 0;
                    put(rq.who, ST_REL_DELETED, 0);
                end
                else if (l_fill[l] > 0) begin
                    put(rq.who, ST_REL_HANDED, 0);
                    pass_lock_on(l);
                end
                else begin
                    pass_lock_on(l);
                    put(rq.who, ST_RELEASED, 0);
                end
            OP_DESTROY_LOCK:
                if (!lock_valid(l)) put(rq.who, ST_BAD_LOCK, 0);
                else if (l_busy[l]) begin
                    l_delp[l] = 1; put(rq.who, ST_DELETE_LATER, 0);
                end
                else begin
                    l_del[l] = 1; put(rq.who, ST_DESTROYED, 0);
                end
            OP_CREATE_COND:
                if (n_conds >= NC) put(rq.who, ST_TOO_MANY, 0);
                else begin
                    c_delp[n_conds] = 0; c_del[n_conds] = 0; c_bound[n_conds] = 0;
                    c_lock[n_conds] = 0; c_head[n_conds] = 0; c_fill[n_conds] = 0;
                    put(rq.who, ST_CREATED, n_conds[5:0]);
                    n_conds++;
                end
            OP_WAIT:
                if (!lock_valid(l)) put(rq.who, ST_BAD_LOCK, 0);
                else if (!cond_valid(c)) put(rq.who, ST_BAD_COND, 0);
                else if (!(l_busy[l] && l_owner[l] == rq.who)) put(rq.who, ST_NOT_ACQUIRED, 0);
                else if (c_delp[c]) put(rq.who, ST_COND_CLOSING, 0);
                else if (c_bound[c] && c_lock[c] != l) put(rq.who, ST_NO_PERMISSION, 0);
                else if (c_fill[c] >= WD) put(rq.who, ST_QUEUE_FULL, 0);
                else begin
                    c_bound[c] = 1; c_lock[c] = l;
                    c_q[c][(c_head[c] + c_fill[c]) % WD] = rq.who;
                    c_fill[c]++;
                    pass_lock_on(l);
                end
            OP_SIGNAL:
                if (!cond_valid(c)) put(rq.who, ST_BAD_COND, 0);
                else if (c_fill[c] == 0) begin
                    c_bound[c] = 0; c_lock[c] = 0;
                    put(rq.who, ST_NO_WAITER, 0);
                end
                else begin
                    acquire_on_behalf(l, pop_cond_waiter(c));
                    if (c_fill[c] == 0) begin
                        c_bound[c] = 0; c_lock[c] = 0;
                    end
                    put(rq.who, ST_SIGNALLED, 0);
                end
            OP_BROADCAST:
                if (!lock_valid(l)) put(rq.who, ST_BAD_LOCK, 0);
                else if (!cond_valid(c)) put(rq.who, ST_BAD_COND, 0);
                else if (c_bound[c] && c_lock[c] != l) put(rq.who, ST_NO_PERMISSION, 0);
                else begin
                    while (c_fill[c] > 0) acquire_on_behalf(l, pop_cond_waiter(c));
                    c_bound[c] = 0; c_lock[c] = 0;
                    put(rq.who, ST_SIGNALLED, 0);
                end
            OP_DESTROY_COND:
                if (!cond_valid(c)) put(rq.who, ST_BAD_COND, 0);
                else if (c_fill[c] == 0) begin
                    c_del[c] = 1; put(rq.who, ST_DESTROYED, 0);
                end
                else begin
                    c_delp[c] = 1; put(rq.who, ST_DELETE_LATER, 0);
                end
            default: ;
        endcase
        n = batch.size();
        if (n > 0) batch[n-1].last = 1'b1;
        foreach (batch[i]) expected_replies.push_back(batch[i]);
        return n;
    endfunction

    // Sends one request transfer after a random, non-empty idle gap.
    task automatic send_request(input req_t rq);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
            : (($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 3));
        repeat (gap) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rq.who[3:0], rq.who[11:4], rq.cv, rq.lk, rq.op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        void'(predict_replies(rq));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_replies.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Receiver: random stalls, and a long hold when the stimulus asks for it.
    initial begin : receiver
        int stall;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_output) m_axis_tready <= 1'b0;
            else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(1, 3);
                repeat (stall - 1) @(posedge clk);
            end
            else m_axis_tready <= 1'b1;
        end
    end

    // Checks each reply transfer against the oldest expectation.
    always @(posedge clk) begin
        reply_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0)
                report($sformatf("unexpected reply %h last %b", m_axis_tdata, m_axis_tlast));
            else begin
                exp_r = expected_replies.pop_front();
                if (m_axis_tdata[7:0] !== exp_r.who[11:4])
                    report($sformatf("dest_machine %h, want %h", m_axis_tdata[7:0],
                                     exp_r.who[11:4]));
                if (m_axis_tdata[11:8] !== exp_r.who[3:0])
                    report($sformatf("dest_mailbox %h, want %h", m_axis_tdata[11:8],
                                     exp_r.who[3:0]));
                if (m_axis_tdata[16:12] !== exp_r.status)
                    report($sformatf("status %0d, want %0d", m_axis_tdata[16:12],
                                     exp_r.status));
                if (m_axis_tdata[22:17] !== exp_r.idx)
                    report($sformatf("new_index %0d, want %0d", m_axis_tdata[22:17],
                                     exp_r.idx));
                if (m_axis_tlast !== exp_r.last)
                    report($sformatf("tlast %b, want %b", m_axis_tlast, exp_r.last));
            end
        end
    end

    function automatic req_t mk(input logic [3:0] op, input int lk, input int cv,
                                input logic [11:0] who);
        req_t r;
        r.op = op; r.lk = lk[5:0]; r.cv = cv[5:0]; r.who = who;
        return r;
    endfunction

    // Random request aimed at the few live objects, with some noise.
    function automatic req_t random_request(input int live);
        req_t r;
        r.op  = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(1, 8));
        if ($urandom_range(0, 30) == 0) r.op = OP_CREATE_LOCK;
        if ($urandom_range(0, 30) == 0) r.op = OP_CREATE_COND;
        r.lk  = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, live));
        r.cv  = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, live));
        r.who = ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                            : {8'($urandom_range(0, 3)), 4'($urandom)};
        if ($urandom_range(0, 3) == 0) r.who = {8'hFF, 4'hF} ^ 12'($urandom_range(0, 3));
        return r;
    endfunction

    initial begin : stimulus
        row_t table_rows[$];
        row_t rw;
        reply_t head;
        int target;
        n_locks = 0; n_conds = 0;
        foreach (l_busy[i]) begin
            l_busy[i] = 0; l_delp[i] = 0; l_del[i] = 0; l_head[i] = 0; l_fill[i] = 0;
        end
        foreach (c_del[i]) begin
            c_delp[i] = 0; c_del[i] = 0; c_bound[i] = 0; c_head[i] = 0; c_fill[i] = 0;
        end
        // Directed part: fixed first status where it is obvious, else model only.
        table_rows.push_back('{mk(OP_ACQUIRE, 0, 0, 12'h001), 1, ST_BAD_LOCK});
        table_rows.push_back('{mk(OP_SIGNAL, 0, 0, 12'h001), 1, ST_BAD_COND});
        table_rows.push_back('{mk(OP_CREATE_LOCK, 63, 63, 12'hFFF), 1, ST_CREATED});
        table_rows.push_back('{mk(OP_CREATE_COND, 0, 0, 12'h000), 1, ST_CREATED});
        table_rows.push_back('{mk(OP_ACQUIRE, 0, 0, 12'hFFF), 1, ST_GRANTED});
        table_rows.push_back('{mk(OP_ACQUIRE, 0, 0, 12'hFFF), 1, ST_ALREADY_OWNER});
        table_rows.push_back('{mk(OP_ACQUIRE, 0, 0, 12'h001), 0, 0});
        table_rows.push_back('{mk(OP_RELEASE, 0, 0, 12'h002), 1, ST_NO_PERMISSION});
        table_rows.push_back('{mk(OP_WAIT, 0, 0, 12'hFFF), 0, 0});
        table_rows.push_back('{mk(OP_WAIT, 0, 0, 12'h002), 1, ST_NOT_ACQUIRED});
        table_rows.push_back('{mk(OP_WAIT, 0, 5, 12'h001), 1, ST_BAD_COND});
        table_rows.push_back('{mk(OP_SIGNAL, 0, 0, 12'h123), 0, 0});
        table_rows.push_back('{mk(OP_RELEASE, 0, 0, 12'h001), 0, 0});
        table_rows.push_back('{mk(OP_SIGNAL, 0, 0, 12'h123), 1, ST_NO_WAITER});
        table_rows.push_back('{mk(OP_BROADCAST, 0, 0, 12'h456), 0, 0});
        table_rows.push_back('{mk(OP_DESTROY_COND, 0, 0, 12'h456), 0, 0});
        table_rows.push_back('{mk(OP_DESTROY_LOCK, 0, 0, 12'h010), 0, 0});
        table_rows.push_back('{mk(OP_RELEASE, 0, 0, 12'hFFF), 0, 0});
        table_rows.push_back('{mk(4'd15, 0, 0, 12'h000), 0, 0});
        table_rows.push_back('{mk(OP_CREATE_LOCK, 0, 0, 12'h020), 1, ST_CREATED});
        table_rows.push_back('{mk(OP_CREATE_COND, 0, 0, 12'h020), 1, ST_CREATED});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i]) begin
            rw = table_rows[i];
            send_request(rw.rq);
            if (rw.has_fixed) begin
                if (batch.size() == 0)
                    report($sformatf("row %0d predicted no reply", i));
                else begin
                    head = batch[0];
                    if (head.status !== rw.fixed_status)
                        report($sformatf("row %0d predicted status %0d, table %0d", i,
                                         head.status, rw.fixed_status));
                end
            end
        end
        wait_drained();

        // Long receiver hold while requests that always reply keep coming,
        // so the output register fills and the input stalls; then a full drain.
        hold_output = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_output = 1'b0;
            end
            for (int k = 0; k < 12; k++) send_request(mk(OP_SIGNAL, 1, 1, 12'($urandom)));
        join
        wait_drained();

        // Fill the waiter queue of lock 1 past its depth.
        for (int k = 0; k < WD + 2; k++)
            send_request(mk(OP_ACQUIRE, 1, 0, 12'(12'h300 + k)));

        // Random part: mostly requests on a handful of live objects.
        target = 100;
        for (int k = 0; k < target; k++) begin
            if (k % 60 == 59) wait_drained();
            send_request(random_request(3 + (k / 80)));
        end

        // Exhaust both tables for the too-many reply.
        for (int k = 0; k < NL + 1; k++)
            send_request(mk(k % 2 ? OP_CREATE_COND : OP_CREATE_LOCK, 0, 0, 12'($urandom)));
        for (int k = 0; k < NL + 1; k++)
            send_request(mk(k % 2 ? OP_CREATE_LOCK : OP_CREATE_COND, 0, 0, 12'($urandom)));
        send_request(mk(OP_ACQUIRE, 63, 63, 12'hABC));
        send_request(mk(OP_BROADCAST, 63, 63, 12'hABC));
        send_request(mk(OP_DESTROY_COND, 63, 63, 12'hABC));

        wait_drained();
        if (error_count == 0)
            $display("lock_and_condition_server_core_tb: clean");
        else
            $display("lock_and_condition_server_core_tb: errors");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("lock_and_condition_server_core_tb: errors");
        $finish;
    end
endmodule
